@@ src/adpcm2_pkg.sv @@
// ----------------------------------------------------------------------------
// adpcm2_pkg
// Shared types, constants and the step scale table for the 2-bit adaptive PCM
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package adpcm2_pkg;

  localparam int STEP_W   = 15;
  localparam int SAMPLE_W = 16;
  localparam int CODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 2;
  localparam int SCALE_W  = 9;
  localparam int PROD_W   = SCALE_W + STEP_W;

  localparam logic [STEP_W-1:0]   STEP_MIN   = 15'd127;
  localparam logic [STEP_W-1:0]   STEP_MAX   = 15'd24576;
  localparam logic [IDX_W-1:0]    LAST_IDX   = 2'd3;
  localparam logic [SAMPLE_W-1:0] SAMPLE_POS = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAMPLE_NEG = 16'h8000;

  localparam logic [SCALE_W-1:0] SCALE_SMALL = 9'd235;
  localparam logic [SCALE_W-1:0] SCALE_LARGE = 9'd341;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  // step adaptation factor, chosen by the magnitude bit
  function automatic logic [SCALE_W-1:0] step_scale(input logic mag);
    logic [SCALE_W-1:0] s;
    s = mag ? SCALE_LARGE : SCALE_SMALL;
    return s;
  endfunction

endpackage

`default_nettype wire

@@ src/adpcm_2bit_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// adpcm_2bit_decoder_unit
// Decodes one byte of four packed 2-bit adaptive PCM codes into four signed
// 16-bit samples, lowest code first, the fourth one marked last.
// ----------------------------------------------------------------------------
// Order: an accepted byte word moves the sequencer from IDLE to BUSY, then each
// code's sample is registered; one sample per cycle while out_ready is high.
// Throughput: one code per cycle through the single step multiplier while the
// output is not stalled; a byte is taken in its own cycle, only in IDLE.
// Reset: step size returns to 127, the predicted sample to 0, output empty.
`default_nettype none

module adpcm_2bit_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  code_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] sample,
  output logic             last
);

  adpcm2_pkg::state_t state;
  adpcm2_pkg::state_t state_next;

  logic [adpcm2_pkg::STEP_W-1:0]   step;
  logic [adpcm2_pkg::SAMPLE_W-1:0] pred;
  logic [adpcm2_pkg::BYTE_W-1:0]   codes;
  logic [adpcm2_pkg::IDX_W-1:0]    idx;

  logic                            mag;
  logic                            neg;
  logic                            advance;
  logic [adpcm2_pkg::STEP_W+1:0]   step3;
  logic [adpcm2_pkg::STEP_W-2:0]   diff;
  logic [adpcm2_pkg::SAMPLE_W:0]   acc;
  logic [adpcm2_pkg::SAMPLE_W-1:0] pred_next;
  logic [adpcm2_pkg::PROD_W-1:0]   prod;
  logic [adpcm2_pkg::SAMPLE_W-1:0] nstep;
  logic [adpcm2_pkg::STEP_W-1:0]   step_next;

  // handshake: byte taken only between bytes, a code advances when the
  // output register is free or being emptied
  assign in_ready = (state == adpcm2_pkg::ST_IDLE);
  assign advance  = (state == adpcm2_pkg::ST_BUSY) && (!out_valid || out_ready);

  // current code fields
  assign mag = codes[0];
  assign neg = codes[1];

  // difference: step or 3*step, then divide by eight; never reaches 32767
  assign step3 = {2'b00, step}
               + (mag ? {1'b0, step, 1'b0} : {(adpcm2_pkg::STEP_W+2){1'b0}});
  assign diff  = step3[adpcm2_pkg::STEP_W+1:3];

  // running sample with saturation when the 17-bit sum overflows 16 bits
  always_comb begin
    if (neg) begin
      acc = {pred[adpcm2_pkg::SAMPLE_W-1], pred} - {3'b000, diff};
    end else begin
      acc = {pred[adpcm2_pkg::SAMPLE_W-1], pred} + {3'b000, diff};
    end
    if (acc[adpcm2_pkg::SAMPLE_W] != acc[adpcm2_pkg::SAMPLE_W-1]) begin
      pred_next = acc[adpcm2_pkg::SAMPLE_W] ? adpcm2_pkg::SAMPLE_NEG : adpcm2_pkg::SAMPLE_POS;
    end else begin
      pred_next = acc[adpcm2_pkg::SAMPLE_W-1:0];
    end
  end

  // step adaptation through the shared multiplier, then clamp
  assign prod  = adpcm2_pkg::step_scale(mag) * step;
  assign nstep = prod[adpcm2_pkg::PROD_W-1:8];

  always_comb begin
    if (nstep < {1'b0, adpcm2_pkg::STEP_MIN}) begin
      step_next = adpcm2_pkg::STEP_MIN;
    end else if (nstep > {1'b0, adpcm2_pkg::STEP_MAX}) begin
      step_next = adpcm2_pkg::STEP_MAX;
    end else begin
      step_next = nstep[adpcm2_pkg::STEP_W-1:0];
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      adpcm2_pkg::ST_IDLE: begin
        if (in_valid) state_next = adpcm2_pkg::ST_BUSY;
      end
      adpcm2_pkg::ST_BUSY: begin
        if (advance && idx == adpcm2_pkg::LAST_IDX) state_next = adpcm2_pkg::ST_IDLE;
      end
      default: state_next = adpcm2_pkg::ST_IDLE;
    endcase
  end

  // control and decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adpcm2_pkg::ST_IDLE;
      step      <= adpcm2_pkg::STEP_MIN;
      pred      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        idx <= '0;
      end else if (advance) begin
        idx <= idx + 1'b1;
      end
      if (advance) begin
        step      <= step_next;
        pred      <= pred_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // code shift register and output word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      codes <= code_byte;
    end else if (advance) begin
      codes <= {2'b00, codes[adpcm2_pkg::BYTE_W-1:adpcm2_pkg::CODE_W]};
    end
    if (advance) begin
      sample <= pred_next;
      last   <= (idx == adpcm2_pkg::LAST_IDX);
    end
  end

  // step size stays within its adaptation bounds
  a_step_bounds: assert property (@(posedge clk) disable iff (rst)
    (step >= adpcm2_pkg::STEP_MIN) && (step <= adpcm2_pkg::STEP_MAX))
    else $error("step size out of bounds");

  // an accepted byte starts at its first code
  a_byte_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == adpcm2_pkg::ST_BUSY) && (idx == '0))
    else $error("byte did not start at first code");

  // a stalled output holds the decoder state
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == adpcm2_pkg::ST_BUSY && out_valid && !out_ready)
      |=> $stable(idx) && $stable(pred) && $stable(step))
    else $error("decoder advanced while output stalled");

  // the last sample leaves only on the fourth code
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    advance |=> (last == ($past(idx) == adpcm2_pkg::LAST_IDX)))
    else $error("last flag on wrong code");

endmodule

`default_nettype wire

@@ bench/adpcm_2bit_decoder_checker.sv @@
// ----------------------------------------------------------------------------
// adpcm_2bit_decoder_checker
// Watches both channels of the 2-bit adaptive PCM decoder. Every accepted code
// byte is run through a local decoder model, which queues four predicted
// samples. Every delivered sample is compared field by field with the oldest
// one. Mismatches and unexpected samples are counted for the testbench top.
// ----------------------------------------------------------------------------
module adpcm_2bit_decoder_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [adpcm2_pkg::BYTE_W-1:0]         code_byte,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [adpcm2_pkg::SAMPLE_W-1:0] sample,
  input  logic                                  last,
  output int                                    mismatch_count,
  output int                                    outstanding,
  output int                                    samples_checked,
  output int                                    clip_hits,
  output int                                    step_ceiling_hits,
  output int                                    step_floor_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [adpcm2_pkg::SAMPLE_W-1:0] sample;
    logic                                   last;
  } decoded_word_t;

  localparam int LEVEL_TOP    = 32767;
  localparam int LEVEL_BOTTOM = -32768;

  decoded_word_t                          expected_samples[$];
  logic [adpcm2_pkg::STEP_W-1:0]          step_now;
  logic signed [adpcm2_pkg::SAMPLE_W-1:0] level_now;

  initial begin
    mismatch_count    = 0;
    outstanding       = 0;
    samples_checked   = 0;
    clip_hits         = 0;
    step_ceiling_hits = 0;
    step_floor_hits   = 0;
  end

  // one code through the decoder: new level out, level and step updated
  function automatic logic signed [adpcm2_pkg::SAMPLE_W-1:0] decode_code(
    input logic [adpcm2_pkg::CODE_W-1:0] code
  );
    int unsigned delta;
    int unsigned next_step;
    int          acc;
    delta     = ((32'd1 + 32'd2 * code[0]) * step_now) >> 3;
    next_step = ((code[0] ? adpcm2_pkg::SCALE_LARGE : adpcm2_pkg::SCALE_SMALL)
                 * step_now) >> 8;
    if (delta > 32'd32767) delta = 32'd32767;
    acc = code[1] ? int'(level_now) - int'(delta) : int'(level_now) + int'(delta);
    if (acc > LEVEL_TOP) begin
      acc = LEVEL_TOP;
      clip_hits++;
    end
    if (acc < LEVEL_BOTTOM) begin
      acc = LEVEL_BOTTOM;
      clip_hits++;
    end
    level_now = acc[adpcm2_pkg::SAMPLE_W-1:0];
    if (next_step < adpcm2_pkg::STEP_MIN) begin
      next_step = 32'(adpcm2_pkg::STEP_MIN);
      step_floor_hits++;
    end
    if (next_step > adpcm2_pkg::STEP_MAX) begin
      next_step = 32'(adpcm2_pkg::STEP_MAX);
      step_ceiling_hits++;
    end
    step_now = next_step[adpcm2_pkg::STEP_W-1:0];
    return level_now;
  endfunction

  always @(posedge clk) begin
    decoded_word_t want;
    decoded_word_t word;
    if (rst) begin
      step_now  = adpcm2_pkg::STEP_MIN;
      level_now = '0;
      expected_samples.delete();
      outstanding <= 0;
    end else begin
      // delivered sample against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected sample %0d last %0b", $realtime, sample, last);
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (sample !== want.sample || last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("[%0t] sample %0d: expected %0d last %0b, got %0d last %0b",
                       $realtime, samples_checked, want.sample, want.last, sample, last);
          end
        end
      end
      // four predicted samples per accepted byte, lowest code first
      if (in_valid && in_ready) begin
        for (int k = 0; k < 4; k++) begin
          word.sample = decode_code(code_byte[2*k +: adpcm2_pkg::CODE_W]);
          word.last   = (k == adpcm2_pkg::LAST_IDX);
          expected_samples.push_back(word);
        end
      end
      outstanding <= expected_samples.size();
    end
  end

endmodule

@@ bench/adpcm_2bit_decoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// adpcm_2bit_decoder_unit_tb
// Drives code bytes into the 2-bit adaptive PCM decoder with random gaps on
// both channels: a directed opening that walks the step to both bounds and the
// level into both rails, then random runs of bytes. The checker predicts and
// compares; this top makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module adpcm_2bit_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 370;
  localparam int CYCLE_LIMIT  = 200000;

  // random byte shapes, chosen per run
  typedef enum int {
    RUN_ANY,
    RUN_LARGE,
    RUN_SMALL,
    RUN_RISE,
    RUN_FALL
  } run_kind_t;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  logic [adpcm2_pkg::BYTE_W-1:0]          code_byte = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic signed [adpcm2_pkg::SAMPLE_W-1:0] sample;
  logic                                   last;

  int  mismatch_count;
  int  outstanding;
  int  samples_checked;
  int  clip_hits;
  int  step_ceiling_hits;
  int  step_floor_hits;
  int  cycle_count = 0;
  int  bytes_sent = 0;
  bit  calm = 1'b0;

  adpcm_2bit_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_byte (code_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .last      (last)
  );

  adpcm_2bit_decoder_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .code_byte         (code_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .sample            (sample),
    .last              (last),
    .mismatch_count    (mismatch_count),
    .outstanding       (outstanding),
    .samples_checked   (samples_checked),
    .clip_hits         (clip_hits),
    .step_ceiling_hits (step_ceiling_hits),
    .step_floor_hits   (step_floor_hits)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still due", cycle_count, outstanding);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // sample receiver: stalls on about 28 percent of cycles unless calm
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 28);
  end

  // offer one byte word, with random idle cycles ahead of it
  task automatic send_byte(input logic [adpcm2_pkg::BYTE_W-1:0] b);
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // hold the sender until every predicted sample has come out
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [adpcm2_pkg::BYTE_W-1:0] shaped_byte(input run_kind_t kind);
    logic [adpcm2_pkg::BYTE_W-1:0] r;
    r = 8'($urandom_range(255));
    case (kind)
      RUN_LARGE: shaped_byte = r | 8'h55;
      RUN_SMALL: shaped_byte = r & 8'hAA;
      RUN_RISE:  shaped_byte = (r & 8'h55);
      RUN_FALL:  shaped_byte = r | 8'hAA;
      default:   shaped_byte = r;
    endcase
  endfunction

  initial begin
    run_kind_t kind;
    int        run_left;
    int        n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: step floor, each code, both orders, then both rails
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h1B);
    send_byte(8'hE4);
    repeat (7) send_byte(8'h55);
    repeat (7) send_byte(8'hFF);
    repeat (3) send_byte(8'hAA);
    drain();

    // random runs of shaped bytes, a quiet stretch in the middle
    run_left = 0;
    kind     = RUN_ANY;
    for (n = 0; n < RANDOM_BYTES; n++) begin
      if (run_left == 0) begin
        kind     = run_kind_t'($urandom_range(4));
        run_left = $urandom_range(16, 1);
      end
      calm = (n >= 150 && n < 230);
      if (n == 100) drain();
      send_byte(shaped_byte(kind));
      run_left--;
    end
    calm = 1'b0;

    // wait out the tail
    drain();
    repeat (8) @(posedge clk);

    $display("%0d bytes decoded, %0d samples compared", bytes_sent, samples_checked);
    $display("rail clips %0d, step held at ceiling %0d and floor %0d times",
             clip_hits, step_ceiling_hits, step_floor_hits);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
